// ===== sv/utv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package utv_pkg;

  localparam int unsigned MAX_LENGTH = 512;

  // Byte counter saturates at MAX_LENGTH + 1
  localparam int unsigned CntW = $clog2(MAX_LENGTH + 2);
  localparam logic [CntW-1:0] CntSat = CntW'(MAX_LENGTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_LENGTH);

  localparam logic [7:0] Lead2Lo   = 8'hC2;
  localparam logic [7:0] Lead2Hi   = 8'hDF;
  localparam logic [7:0] Lead3Lo   = 8'hE0;
  localparam logic [7:0] Lead3Hi   = 8'hEF;
  localparam logic [7:0] Lead4Lo   = 8'hF0;
  localparam logic [7:0] Lead4Hi   = 8'hF4;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] AsciiLim  = 8'h80;

  localparam logic [20:0] Min2     = 21'h00080;
  localparam logic [20:0] Min3     = 21'h00800;
  localparam logic [20:0] Min4     = 21'h10000;
  localparam logic [20:0] MaxCode  = 21'h10FFFF;
  localparam logic [20:0] SurroLo  = 21'h0D800;
  localparam logic [20:0] SurroHi  = 21'h0DFFF;

  localparam logic [1:0] Len2 = 2'd1;
  localparam logic [1:0] Len3 = 2'd2;
  localparam logic [1:0] Len4 = 2'd3;

  typedef struct packed {
    logic [1:0]      pending;
    logic [1:0]      seq_len;
    logic [20:0]     acc;
    logic [CntW-1:0] count;
    logic            err;
  } text_state_t;

endpackage

`default_nettype wire

// ===== sv/utv_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module utv_step (
  input  utv_pkg::text_state_t state_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_i,
  input  logic                 empty_text_i,
  output utv_pkg::text_state_t state_o,
  output logic                 emit_o,
  output logic                 text_valid_o
);
  import utv_pkg::*;

  text_state_t upd;
  logic [20:0] acc_cont;
  logic        bad;

  assign acc_cont = {state_i.acc[14:0], data_byte_i[5:0]};

  always_comb begin
    bad = 1'b0;
    if (state_i.seq_len == Len2 && acc_cont < Min2) bad = 1'b1;
    if (state_i.seq_len == Len3 && acc_cont < Min3) bad = 1'b1;
    if (state_i.seq_len == Len4 && acc_cont < Min4) bad = 1'b1;
    if (acc_cont > MaxCode) bad = 1'b1;
    if (acc_cont >= SurroLo && acc_cont <= SurroHi) bad = 1'b1;
  end

  always_comb begin
    upd = state_i;
    if (state_i.count < CntSat) begin
      upd.count = state_i.count + CntW'(1);
    end
    if (!state_i.err) begin
      if (state_i.pending == 2'd0) begin
        if (data_byte_i < AsciiLim) begin
          upd.pending = 2'd0;
        end else if (data_byte_i >= Lead2Lo && data_byte_i <= Lead2Hi) begin
          upd.acc     = {16'd0, data_byte_i[4:0]};
          upd.seq_len = Len2;
          upd.pending = Len2;
        end else if (data_byte_i >= Lead3Lo && data_byte_i <= Lead3Hi) begin
          upd.acc     = {17'd0, data_byte_i[3:0]};
          upd.seq_len = Len3;
          upd.pending = Len3;
        end else if (data_byte_i >= Lead4Lo && data_byte_i <= Lead4Hi) begin
          upd.acc     = {18'd0, data_byte_i[2:0]};
          upd.seq_len = Len4;
          upd.pending = Len4;
        end else begin
          upd.err = 1'b1;
        end
      end else if ((data_byte_i & ContMask) != ContTag) begin
        upd.err = 1'b1;
      end else begin
        upd.acc     = acc_cont;
        upd.pending = state_i.pending - 2'd1;
        if (state_i.pending == 2'd1 && bad) upd.err = 1'b1;
      end
    end
  end

  always_comb begin
    state_o      = upd;
    emit_o       = 1'b0;
    text_valid_o = 1'b0;
    if (empty_text_i) begin
      state_o = '0;
      emit_o  = 1'b1;
    end else if (last_i) begin
      state_o      = '0;
      emit_o       = 1'b1;
      text_valid_o = !upd.err && upd.pending == 2'd0 && upd.count <= CntMax;
    end
  end

endmodule

`default_nettype wire

// ===== sv/utf8_text_validator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Strict UTF-8 validator for a text that arrives one byte per item on a
// valid/ready channel. The per-byte decode is a single layer of compares and
// shifts between the text state register and the verdict register, so
// throughput is one byte per clock whenever the output side keeps taking
// verdicts. A verdict (text_valid) appears in the cycle after the item marked
// last, or after an item marked empty_text, which always yields 0. Texts longer
// than MAX_LENGTH bytes, cut-off sequences, bad leads, bad continuations,
// overlong forms, surrogates and values above 10FFFF fail.
module utf8_text_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  input  logic       empty_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       text_valid_o
);
  import utv_pkg::*;

  text_state_t state_q, state_d;
  logic        emit;
  logic        verdict;
  logic        out_valid_q, out_valid_d;
  logic        text_valid_q, text_valid_d;
  logic        in_fire;

  utv_step u_step (
    .state_i      (state_q),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .empty_text_i (empty_text_i),
    .state_o      (state_d),
    .emit_o       (emit),
    .text_valid_o (verdict)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    text_valid_d = text_valid_q;
    if (in_fire && emit) begin
      out_valid_d  = 1'b1;
      text_valid_d = verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      out_valid_q  <= 1'b0;
      text_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      text_valid_q <= text_valid_d;
      if (in_fire) state_q <= state_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign text_valid_o = text_valid_q;

  a_empty_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && empty_text_i |=> out_valid_o && !text_valid_o)
    else $error("empty text did not give a failing verdict");

  a_sticky_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !empty_text_i && last_i && state_q.err |=> out_valid_o && !text_valid_o)
    else $error("error seen but text reported valid");

  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (last_i || empty_text_i) |=> state_q.count == '0 && !state_q.err
      && state_q.pending == 2'd0)
    else $error("text state not cleared after verdict");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.count <= CntSat)
    else $error("byte counter past saturation");

endmodule

`default_nettype wire

// ===== test/tb_utf8_text_validator.sv =====
`timescale 1ns / 1ps

module tb_utf8_text_validator;
  import utv_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_i = 1'b0;
  logic       empty_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       text_valid_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  int unsigned stall_kick = 0;
  int unsigned stall_seen = 0;
  int unsigned stall_left = 0;

  logic       pending_verdicts[$];
  logic [7:0] text_bytes[$];

  logic [1:0]      pend_cnt = '0;
  logic [1:0]      seq_len = '0;
  logic [20:0]     scalar_acc = '0;
  logic [CntW-1:0] byte_cnt = '0;
  logic            err_seen = 1'b0;

  utf8_text_validator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .empty_text_i (empty_text_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .text_valid_o (text_valid_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endtask

  task automatic queue_verdict(input logic v);
    pending_verdicts.insert(pending_verdicts.size(), v);
  endtask

  task automatic add_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  task automatic clear_text_state();
    pend_cnt   = '0;
    seq_len    = '0;
    scalar_acc = '0;
    byte_cnt   = '0;
    err_seen   = 1'b0;
  endtask

  task automatic update_text_state(input logic [7:0] b, input logic l, input logic e);
    if (e) begin
      clear_text_state();
      queue_verdict(1'b0);
      return;
    end
    if (byte_cnt != CntSat) byte_cnt++;
    if (!err_seen) begin
      if (pend_cnt == 2'd0) begin
        if (b < AsciiLim) begin
        end else if (b >= Lead2Lo && b <= Lead2Hi) begin
          scalar_acc = 21'(b & 8'h1F);
          seq_len    = Len2;
          pend_cnt   = Len2;
        end else if (b >= Lead3Lo && b <= Lead3Hi) begin
          scalar_acc = 21'(b & 8'h0F);
          seq_len    = Len3;
          pend_cnt   = Len3;
        end else if (b >= Lead4Lo && b <= Lead4Hi) begin
          scalar_acc = 21'(b & 8'h07);
          seq_len    = Len4;
          pend_cnt   = Len4;
        end else begin
          err_seen = 1'b1;
        end
      end else if ((b & ContMask) != ContTag) begin
        err_seen = 1'b1;
      end else begin
        scalar_acc = {scalar_acc[14:0], b[5:0]};
        pend_cnt   = pend_cnt - 2'd1;
        if (pend_cnt == 2'd0 &&
            ((seq_len == Len2 && scalar_acc < Min2) ||
             (seq_len == Len3 && scalar_acc < Min3) ||
             (seq_len == Len4 && scalar_acc < Min4) ||
             scalar_acc > MaxCode ||
             (scalar_acc >= SurroLo && scalar_acc <= SurroHi)))
          err_seen = 1'b1;
      end
    end
    if (l) begin
      queue_verdict(!err_seen && pend_cnt == 2'd0 && byte_cnt != '0 &&
                    byte_cnt <= CntMax);
      clear_text_state();
    end
  endtask

  always @(posedge clk_i) begin
    logic want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) update_text_state(data_byte_i, last_i, empty_text_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_verdicts.size() == 0) begin
          note_failure($sformatf("unexpected verdict text_valid=%b", text_valid_o));
        end else begin
          want = pending_verdicts.pop_front();
          if (text_valid_o !== want)
            note_failure($sformatf("text_valid mismatch: expected %b, actual %b",
                                   want, text_valid_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_kick != stall_seen) begin
      stall_seen = stall_kick;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic l, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    last_i       <= l;
    empty_text_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_text(input bit allow_abort);
    foreach (text_bytes[i]) begin
      if (allow_abort && $urandom_range(99) < 2)
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      send_item(text_bytes[i], i == text_bytes.size() - 1, 1'b0);
    end
  endtask

  task automatic add_scalar(input logic [20:0] cp, input int k);
    case (k)
      1: add_byte(cp[7:0]);
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic add_valid_scalar(input int k);
    logic [20:0] cp;
    case (k)
      1: cp = 21'($urandom_range(8'h7F));
      2: cp = 21'($urandom_range(Min2, Min3 - 1));
      3: begin
        cp = 21'($urandom_range(Min3, Min4 - 1));
        if (cp >= SurroLo && cp <= SurroHi) cp ^= 21'h2000;
      end
      default: cp = 21'($urandom_range(Min4, MaxCode));
    endcase
    add_scalar(cp, k);
  endtask

  task automatic build_valid_text(input int n);
    int room;
    text_bytes.delete();
    while (text_bytes.size() < n) begin
      room = n - text_bytes.size();
      add_valid_scalar($urandom_range(1, room < 4 ? room : 4));
    end
  endtask

  task automatic send_random_text();
    int k;
    text_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(99) < 85) begin
        add_valid_scalar($urandom_range(1, 4));
      end else begin
        case ($urandom_range(5))
          0: add_byte(8'($urandom_range(255)));
          1: add_byte($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hC1))
                                        : 8'($urandom_range(8'hF5, 8'hFF)));
          2: begin
            k = $urandom_range(2, 4);
            add_scalar(21'($urandom_range(k == 2 ? Min2 - 1 : k == 3 ? Min3 - 1 : Min4 - 1)),
                       k);
          end
          3: add_scalar(21'($urandom_range(SurroLo, SurroHi)), 3);
          4: add_scalar(21'($urandom_range(MaxCode + 1, 21'h1FFFFF)), 4);
          default: begin
            add_byte(8'($urandom_range(Lead2Lo, Lead4Hi)));
            add_byte($urandom_range(1) ? 8'($urandom_range(8'h7F))
                                       : 8'($urandom_range(8'hC0, 8'hFF)));
          end
        endcase
      end
    end
    if ($urandom_range(99) < 10 && text_bytes.size() > 1) void'(text_bytes.pop_back());
    if ($urandom_range(99) < 4)
      send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    else
      send_text(1'b1);
  endtask

  task automatic test_directed();
    text_bytes = '{8'h00, 8'h7F};
    send_text(1'b0);
    text_bytes = '{8'hC1};
    send_text(1'b0);
    text_bytes = '{8'hFF};
    send_text(1'b0);
    text_bytes = '{8'hE0, 8'h9F, 8'hBF};
    send_text(1'b0);
    text_bytes = '{8'hED, 8'hA0, 8'h80};
    send_text(1'b0);
    text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text(1'b0);
    text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text(1'b0);
    text_bytes = '{8'hC2};
    send_text(1'b0);
    text_bytes = '{8'hC2, 8'h41, 8'hC2, 8'h80};
    send_text(1'b0);
    send_item(8'hE0, 1'b0, 1'b0);
    send_item(8'hA0, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_texts(input int unsigned src_pct, input int unsigned snk_pct,
                                   input int unsigned count);
    int unsigned start;
    send_idle_pct = src_pct;
    recv_idle_pct = snk_pct;
    start = items_sent;
    while (items_sent - start < count) send_random_text();
  endtask

  task automatic test_length_limit();
    build_valid_text(MAX_LENGTH);
    send_text(1'b0);
    build_valid_text(MAX_LENGTH + 3);
    send_text(1'b0);
  endtask

  task automatic test_backpressure();
    int unsigned start;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_kick++;
    start = items_sent;
    while (items_sent - start < 40) send_random_text();
  endtask

  initial begin
    send_idle_pct = 13;
    recv_idle_pct = 72;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_texts(13, 72, 130);
    test_random_texts(72, 13, 130);
    test_random_texts(0, 0, 130);
    test_length_limit();
    test_backpressure();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_verdicts.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/utv_pkg.sv
sv/utv_step.sv
sv/utf8_text_validator.sv
test/tb_utf8_text_validator.sv
